FILE: sv/rled_pkg.sv
// ----------------------------------------------------------------------------
// rled_pkg
// Shared types and constants for the run-length image decoder: transaction
// payloads, the command phase enum and the status codes.
// ----------------------------------------------------------------------------
package rled_pkg;

  // Width of the pixel accounting counter and of the image size limit
  localparam int unsigned PixelCountBits = 24;
  localparam int unsigned CfgBits        = 24;

  // Literal count byte carries the run length plus this offset
  localparam logic [7:0] LiteralBias = 8'd2;

  typedef enum logic [1:0] {
    PH_CMD     = 2'd0,
    PH_COUNT   = 2'd1,
    PH_LITERAL = 2'd2,
    PH_COLOR   = 2'd3
  } rled_phase_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_TRUNC = 2'd1,
    STAT_SIZE  = 2'd2
  } rled_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rled_in_t;

  typedef struct packed {
    logic [7:0]   pixel;
    logic [7:0]   run_length;
    logic         end_of_image;
    rled_status_e status;
  } rled_out_t;

endpackage

FILE: sv/rled_core.sv
// ----------------------------------------------------------------------------
// rled_core
// Input register and command phase machine. Each registered byte updates the
// stream state and produces at most one run descriptor in the same cycle.
// ----------------------------------------------------------------------------
module rled_core
  import rled_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rled_in_t                  in_data_i,
  input  logic [PixelCountBits-1:0] limit_i,
  input  logic                      room_i,
  output logic                      push_o,
  output rled_out_t                 push_data_o
);

  logic                      in_vld_q;
  rled_in_t                  in_q;
  rled_phase_e               phase_q, phase_d;
  logic [7:0]                lit_left_q, lit_left_d;
  logic [7:0]                fill_len_q, fill_len_d;
  logic [PixelCountBits-1:0] written_q, written_d;
  rled_status_e              err_q, err_d;

  logic                      advance;
  logic                      emit;
  logic [7:0]                cnt;
  logic [7:0]                lit_dec;
  logic [7:0]                run_len;
  logic [PixelCountBits:0]   sum;
  logic                      fits;

  // Take a new byte whenever the holding register is free or moving on
  assign advance    = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Size check shared by literal count and fill color
  assign cnt     = in_q.data_byte - LiteralBias;
  assign lit_dec = lit_left_q - 8'd1;
  assign run_len = (phase_q == PH_COUNT) ? cnt : fill_len_q;
  assign sum     = {1'b0, written_q} + {{(PixelCountBits - 7){1'b0}}, run_len};
  assign fits    = sum <= {1'b0, limit_i};

  // Next stream state
  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    fill_len_d = fill_len_q;
    written_d  = written_q;
    err_d      = err_q;
    emit       = 1'b0;
    if (err_q == STAT_OK) begin
      case (phase_q)
        PH_CMD: begin
          if (in_q.data_byte == 8'd0) begin
            phase_d = PH_COUNT;
          end else begin
            fill_len_d = in_q.data_byte;
            phase_d    = PH_COLOR;
          end
          if (in_q.last_byte) begin
            err_d = STAT_TRUNC;
          end
        end
        PH_COUNT: begin
          if (in_q.last_byte && cnt != 8'd0) begin
            err_d = STAT_TRUNC;
          end else if (!fits) begin
            err_d = STAT_SIZE;
          end else begin
            written_d  = sum[PixelCountBits-1:0];
            lit_left_d = cnt;
            phase_d    = (cnt != 8'd0) ? PH_LITERAL : PH_CMD;
          end
        end
        PH_LITERAL: begin
          emit       = 1'b1;
          lit_left_d = lit_dec;
          if (lit_dec == 8'd0) begin
            phase_d = PH_CMD;
          end else if (in_q.last_byte) begin
            err_d = STAT_TRUNC;
          end
        end
        default: begin
          if (!fits) begin
            err_d = STAT_SIZE;
          end else begin
            written_d = sum[PixelCountBits-1:0];
            emit      = 1'b1;
            phase_d   = PH_CMD;
          end
        end
      endcase
    end
  end

  // Build the result transaction
  always_comb begin
    push_o                   = advance && (emit || in_q.last_byte);
    push_data_o.pixel        = emit ? in_q.data_byte : 8'd0;
    push_data_o.run_length   = 8'd0;
    if (emit) begin
      push_data_o.run_length = (phase_q == PH_LITERAL) ? 8'd1 : fill_len_q;
    end
    push_data_o.end_of_image = in_q.last_byte;
    push_data_o.status       = in_q.last_byte ? err_d : STAT_OK;
  end

  // Update state; the last byte of a stream restarts it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CMD;
      lit_left_q <= 8'd0;
      fill_len_q <= 8'd0;
      written_q  <= '0;
      err_q      <= STAT_OK;
    end else if (advance) begin
      if (in_q.last_byte) begin
        phase_q    <= PH_CMD;
        lit_left_q <= 8'd0;
        fill_len_q <= 8'd0;
        written_q  <= '0;
        err_q      <= STAT_OK;
      end else begin
        phase_q    <= phase_d;
        lit_left_q <= lit_left_d;
        fill_len_q <= fill_len_d;
        written_q  <= written_d;
        err_q      <= err_d;
      end
    end
  end

  // A run never pushes the accounted pixel count past the limit
  a_written_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == STAT_OK) |-> (written_q <= limit_i))
    else $error("pixel count exceeds image size");

  // Once an error is latched only the closing transaction goes out
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && err_q != STAT_OK) |-> (push_data_o.end_of_image &&
                                      push_data_o.run_length == 8'd0))
    else $error("run emitted after error");

endmodule

FILE: sv/rled_out_q.sv
// ----------------------------------------------------------------------------
// rled_out_q
// Two-entry result queue. Decouples the downstream ready from the decoder so
// that a new byte is taken while a finished run waits to be read.
// ----------------------------------------------------------------------------
module rled_out_q
  import rled_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rled_out_t push_data_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rled_out_t out_data_o
);

  rled_out_t   mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic        pop;

  assign room_o      = count_q != 2'd2;
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("result queue pointers out of step");

endmodule

FILE: sv/rle_image_decoder.sv
// An accepted byte is held in the input register; its run descriptor is then written
//   into the result queue, whose head drives the output.
// Throughput: one byte per cycle while the result queue has room.
// Bytes that close no run, other than the last byte of a stream, are consumed without a result transaction.
// Reset (rst_ni low, asynchronous): stream state idle, queue empty, image
//   size register zero.
// ----------------------------------------------------------------------------
// rle_image_decoder
// Streaming byte run-length decoder. Turns compressed bytes into run
// descriptors and flags truncation and image size overflow.
// ----------------------------------------------------------------------------
module rle_image_decoder
  import rled_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rled_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rled_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i
);

  logic [CfgBits-1:0]        image_pixels_q;
  logic [31:0]               image_pixels_ext;
  logic [PixelCountBits-1:0] limit;
  logic                      room;
  logic                      push;
  rled_out_t                 push_data;

  // Hold the image size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_pixels_q <= '0;
    end else if (cfg_we_i) begin
      image_pixels_q <= cfg_wdata_i;
    end
  end

  // Fit the limit to the pixel counter width
  assign image_pixels_ext = {{(32 - CfgBits){1'b0}}, image_pixels_q};
  assign limit            = image_pixels_ext[PixelCountBits-1:0];

  rled_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .limit_i     (limit),
    .room_i      (room),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rled_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/rle_image_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_image_decoder_checker
// Watches the byte and run descriptor channels of the run-length decoder,
// predicts each run descriptor from the accepted bytes and the image size
// register, and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module rle_image_decoder_checker
  import rled_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  rled_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  rled_out_t          out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        runs_pending_o
);

  localparam int unsigned MaxReports = 10;

  // Shadow of the decoder: register, phase machine and pixel accounting
  logic [CfgBits-1:0]        image_pixels;
  rled_phase_e               phase;
  logic [7:0]                literal_left;
  logic [7:0]                fill_len;
  logic [PixelCountBits-1:0] pixels_written;
  rled_status_e              stream_err;

  rled_out_t                 expected_runs[$];

  function automatic logic run_fits(input logic [7:0] len);
    logic [PixelCountBits:0] total;
    total = {1'b0, pixels_written} + (PixelCountBits + 1)'(len);
    return total <= (PixelCountBits + 1)'(image_pixels);
  endfunction

  task automatic restart_stream();
    phase          = PH_CMD;
    literal_left   = '0;
    fill_len       = '0;
    pixels_written = '0;
    stream_err     = STAT_OK;
  endtask

  // Advance the phase machine by one byte and queue the run it yields, if any
  task automatic predict_run(input rled_in_t item);
    logic [7:0] cnt;
    logic       emit;
    rled_out_t  run;
    emit = 1'b0;
    run  = '0;
    if (stream_err == STAT_OK) begin
      case (phase)
        PH_CMD: begin
          if (item.data_byte == 8'd0) begin
            phase = PH_COUNT;
          end else begin
            fill_len = item.data_byte;
            phase    = PH_COLOR;
          end
          if (item.last_byte) stream_err = STAT_TRUNC;
        end
        PH_COUNT: begin
          cnt = item.data_byte - LiteralBias;
          if (item.last_byte && cnt != 8'd0) begin
            stream_err = STAT_TRUNC;
          end else if (!run_fits(cnt)) begin
            stream_err = STAT_SIZE;
          end else begin
            pixels_written = pixels_written + PixelCountBits'(cnt);
            literal_left   = cnt;
            phase          = (cnt != 8'd0) ? PH_LITERAL : PH_CMD;
          end
        end
        PH_LITERAL: begin
          run.pixel      = item.data_byte;
          run.run_length = 8'd1;
          emit           = 1'b1;
          literal_left   = literal_left - 8'd1;
          if (literal_left == 8'd0) begin
            phase = PH_CMD;
          end else if (item.last_byte) begin
            stream_err = STAT_TRUNC;
          end
        end
        default: begin
          if (!run_fits(fill_len)) begin
            stream_err = STAT_SIZE;
          end else begin
            pixels_written = pixels_written + PixelCountBits'(fill_len);
            run.pixel      = item.data_byte;
            run.run_length = fill_len;
            emit           = 1'b1;
            phase          = PH_CMD;
          end
        end
      endcase
    end
    if (emit || item.last_byte) begin
      run.end_of_image = item.last_byte;
      run.status       = item.last_byte ? stream_err : STAT_OK;
      expected_runs.push_back(run);
      if (item.last_byte) restart_stream();
    end
  endtask

  // Compare one result transaction with the oldest prediction
  task automatic check_run(input rled_out_t got);
    rled_out_t want;
    if (expected_runs.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MaxReports) begin
        $display("%0t: unexpected run: pixel=%h len=%0d eoi=%b status=%0d",
                 $time, got.pixel, got.run_length, got.end_of_image, got.status);
      end
    end else begin
      want = expected_runs.pop_front();
      if (got.pixel !== want.pixel || got.run_length !== want.run_length ||
          got.end_of_image !== want.end_of_image || got.status !== want.status) begin
        fail_count_o++;
        if (fail_count_o <= MaxReports) begin
          $display("%0t: run mismatch: expected pixel=%h len=%0d eoi=%b status=%0d",
                   $time, want.pixel, want.run_length, want.end_of_image, want.status);
          $display("%0t:               got      pixel=%h len=%0d eoi=%b status=%0d",
                   $time, got.pixel, got.run_length, got.end_of_image, got.status);
        end
      end
    end
  endtask

  // Check results first, then predict from the byte taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_pixels = '0;
      restart_stream();
      expected_runs.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_run(out_data_i);
      if (in_valid_i && in_ready_i) predict_run(in_data_i);
      if (cfg_we_i) image_pixels = cfg_wdata_i;
    end
    runs_pending_o = expected_runs.size();
  end

endmodule

FILE: verif/rle_image_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_image_decoder_tb
// Drives compressed byte streams into the run-length decoder under random
// flow control on both channels and several image size settings; a checker
// module beside the decoder predicts and compares the run descriptors.
// ----------------------------------------------------------------------------
module rle_image_decoder_tb;
  import rled_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned RandomItems   = 550;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rled_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  rled_out_t          out_data;
  logic               cfg_we;
  logic [CfgBits-1:0] cfg_wdata;

  int unsigned        fail_count;
  int unsigned        runs_pending;
  int unsigned        idle_cycles;
  int unsigned        bytes_sent;
  bit                 steady;

  rle_image_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  rle_image_decoder_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .runs_pending_o (runs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long; none while steady is set
  function automatic int idle_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CfgBits-1:0] pick_image_size();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return CfgBits'($urandom_range(1, 40));
      3:       return CfgBits'($urandom_range(100, 3000));
      default: return CfgBits'($urandom);
    endcase
  endfunction

  // Stall the result channel at random
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready  = 1'b1;
        stall_left = idle_gap();
      end
    end
  end

  // Reset the no-progress count on every transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_data.data_byte = value;
    in_data.last_byte = is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream(input logic [7:0] stream_q[$]);
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    bytes_sent += stream_q.size();
  endtask

  // Drain, let the pipeline settle, then write the image size register
  task automatic set_image_size(input logic [CfgBits-1:0] value);
    in_valid = 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Build a stream: mostly well-formed commands, some cut short, some noise
  task automatic random_stream();
    logic [7:0] stream_q[$];
    int         kind;
    int         len;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1) == 0) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
          stream_q.push_back(8'd0);
          stream_q.push_back(8'(len) + LiteralBias);
          repeat (len) stream_q.push_back(8'($urandom));
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
          stream_q.push_back(8'(len));
          stream_q.push_back(8'($urandom));
        end
      end
      // Cut some streams short inside a command
      if (kind >= 76 && stream_q.size() > 1) begin
        len = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > len) void'(stream_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
    end
    send_stream(stream_q);
  endtask

  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    steady     = 1'b0;
    bytes_sent = 0;
    rst_n      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty image: empty literal passes, a fill overflows, the rest is dropped
    set_image_size('0);
    send_stream('{8'h00, 8'h02, 8'h05, 8'hAA, 8'h33, 8'h44});

    // Largest image: full fill, literal run, single fill, bare end marker
    set_image_size('1);
    send_stream('{8'hFF, 8'h00, 8'h00, 8'h05, 8'hFF, 8'h80, 8'h01, 8'h01, 8'hFF,
                  8'h00, 8'h02});
    // Truncation on a command, on a count byte and inside a literal run
    send_stream('{8'h07});
    send_stream('{8'h00, 8'h04});
    send_stream('{8'h00, 8'h04, 8'h55});
    // Fill color closing the stream
    send_stream('{8'h03, 8'h12});

    // Random streams under changing image sizes and idle patterns
    bytes_sent = 0;
    while (bytes_sent < RandomItems) begin
      if ($urandom_range(0, 3) == 0) set_image_size(pick_image_size());
      steady = ($urandom_range(0, 99) < 15);
      random_stream();
    end
    steady = 1'b0;

    // Drain and give the verdict
    in_valid = 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
